FILE: src/tsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread suppression filter package
// Shared constants and a name normalizing function for the filter core.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int NameSlots = 32;
  localparam int IdSlots   = 256;

  localparam logic [1:0] ModeAddName  = 2'd0;
  localparam logic [1:0] ModeAddId    = 2'd1;
  localparam logic [1:0] ModeUpdate   = 2'd2;
  localparam logic [1:0] ModeCheckId  = 2'd3;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNameFull = 2'd1;
  localparam logic [1:0] StatusIdFull   = 2'd2;

  // Clear every byte after the first zero byte of a 16-byte name.
  function automatic logic [127:0] normalize_name(input logic [127:0] name);
    logic [127:0] res;
    logic         ended;
    res   = name;
    ended = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (ended) res[8*b +: 8] = 8'h00;
      else if (name[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return res;
  endfunction

endpackage

FILE: src/tsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

FILE: src/thread_suppression_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread suppression filter core
// Name list and thread id set kept in single-port RAMs, searched by a
// sequencer one entry at a time.
// ----------------------------------------------------------------------------
// The time an item takes is set by the linear scans of the name RAMs and of the
// id RAM (parent scan, then thread scan, each entry read and then compared),
// plus any time the output register stays full.
// Throughput: one item at a time; the next item is taken once the result
// word sits in the output register, even while that word still waits.
// Reset clears the name count, the id valid bits, the state register and the
// output valid bit; there is no clearing pass.
module thread_suppression_filter_core #(
  parameter int NAME_SLOTS = tsf_pkg::NameSlots,
  parameter int ID_SLOTS   = tsf_pkg::IdSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_name_low,
  input  logic [63:0] in_name_high,
  input  logic [63:0] in_thread_id,
  input  logic [63:0] in_parent_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_suppressed,
  output logic [1:0]  out_status
);

  localparam int NW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
  localparam int IW = $clog2(ID_SLOTS);
  localparam int NCW = $clog2(NAME_SLOTS + 1);
  localparam int ICW = $clog2(ID_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_NAME_RD, S_NAME_CMP, S_PAR_RD, S_PAR_CMP, S_TID_RD, S_TID_CMP,
    S_DECIDE, S_OUT_WAIT
  } state_t;

  state_t            state_r;
  logic [1:0]        mode_r;
  logic [127:0]      name_r;
  logic [63:0]       tid_r, pid_r;
  logic [NCW-1:0]    name_count_r;
  logic [ID_SLOTS-1:0] id_valid_r;
  logic [NCW-1:0]    nidx_r;
  logic [ICW-1:0]    iidx_r;
  logic              name_hit_r, par_hit_r, tid_hit_r;
  logic [IW-1:0]     tid_slot_r;
  logic              res_sup_r;
  logic [1:0]        res_status_r;
  logic              out_valid_r, out_sup_r;
  logic [1:0]        out_status_r;

  // RAM controls
  logic              n_we, i_we;
  logic [NW-1:0]     n_addr;
  logic [IW-1:0]     i_addr;
  logic [63:0]       i_wdata;
  logic [63:0]       nlo_q, nhi_q, id_q;

  // Lowest free slot from the valid bits, priority encoded.
  logic [IW-1:0]     free_slot;
  logic              free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = ID_SLOTS - 1; i >= 0; i--) begin
      if (!id_valid_r[i]) begin
        free_slot = IW'(i);
        free_any  = 1'b1;
      end
    end
  end

  tsf_ram #(.Width(64), .Depth(1 << NW)) u_name_lo (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(name_r[63:0]), .rdata(nlo_q));
  tsf_ram #(.Width(64), .Depth(1 << NW)) u_name_hi (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(name_r[127:64]), .rdata(nhi_q));
  tsf_ram #(.Width(64), .Depth(ID_SLOTS)) u_id (
    .clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wdata), .rdata(id_q));

  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    n_we    = 1'b0;
    n_addr  = nidx_r[NW-1:0];
    i_we    = 1'b0;
    i_addr  = iidx_r[IW-1:0];
    i_wdata = tid_r;
    if (state_r == S_DECIDE && mode_r == tsf_pkg::ModeAddName && !name_hit_r &&
        name_count_r < NCW'(NAME_SLOTS)) begin
      n_we   = 1'b1;
      n_addr = name_count_r[NW-1:0];
    end
    if (state_r == S_DECIDE && mode_r != tsf_pkg::ModeAddName &&
        mode_r != tsf_pkg::ModeCheckId && !tid_hit_r && free_any &&
        (mode_r == tsf_pkg::ModeAddId || par_hit_r || name_hit_r)) begin
      i_we   = 1'b1;
      i_addr = free_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      name_count_r <= '0;
      id_valid_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A word loaded in the wait state replaces the one leaving in that cycle.
      if (out_valid_r && out_ready && state_r != S_OUT_WAIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r     <= in_mode;
            name_r     <= tsf_pkg::normalize_name({in_name_high, in_name_low});
            tid_r      <= in_thread_id;
            pid_r      <= in_parent_id;
            name_hit_r <= 1'b0;
            par_hit_r  <= 1'b0;
            tid_hit_r  <= 1'b0;
            nidx_r     <= '0;
            iidx_r     <= '0;
            unique case (in_mode)
              tsf_pkg::ModeAddName, tsf_pkg::ModeUpdate: state_r <= S_NAME_RD;
              default: state_r <= S_TID_RD;
            endcase
          end
        end
        S_NAME_RD: begin
          if (nidx_r >= name_count_r) begin
            iidx_r  <= '0;
            state_r <= (mode_r == tsf_pkg::ModeUpdate) ? S_PAR_RD : S_DECIDE;
          end else begin
            state_r <= S_NAME_CMP;
          end
        end
        S_NAME_CMP: begin
          if (nlo_q == name_r[63:0] && nhi_q == name_r[127:64]) begin
            name_hit_r <= 1'b1;
            iidx_r     <= '0;
            state_r    <= (mode_r == tsf_pkg::ModeUpdate) ? S_PAR_RD : S_DECIDE;
          end else begin
            nidx_r  <= nidx_r + 1'b1;
            state_r <= S_NAME_RD;
          end
        end
        S_PAR_RD: begin
          if (iidx_r == ICW'(ID_SLOTS)) begin
            iidx_r  <= '0;
            state_r <= S_TID_RD;
          end else begin
            state_r <= S_PAR_CMP;
          end
        end
        S_PAR_CMP: begin
          if (id_valid_r[iidx_r[IW-1:0]] && id_q == pid_r) begin
            par_hit_r <= 1'b1;
            iidx_r    <= '0;
            state_r   <= S_TID_RD;
          end else begin
            iidx_r  <= iidx_r + 1'b1;
            state_r <= S_PAR_RD;
          end
        end
        S_TID_RD: begin
          if (iidx_r == ICW'(ID_SLOTS)) state_r <= S_DECIDE;
          else state_r <= S_TID_CMP;
        end
        S_TID_CMP: begin
          if (id_valid_r[iidx_r[IW-1:0]] && id_q == tid_r) begin
            tid_hit_r  <= 1'b1;
            tid_slot_r <= iidx_r[IW-1:0];
            state_r    <= S_DECIDE;
          end else begin
            iidx_r  <= iidx_r + 1'b1;
            state_r <= S_TID_RD;
          end
        end
        S_DECIDE: begin
          res_sup_r    <= 1'b0;
          res_status_r <= tsf_pkg::StatusOk;
          unique case (mode_r)
            tsf_pkg::ModeAddName: begin
              if (!name_hit_r) begin
                if (name_count_r < NCW'(NAME_SLOTS)) name_count_r <= name_count_r + 1'b1;
                else res_status_r <= tsf_pkg::StatusNameFull;
              end
            end
            tsf_pkg::ModeAddId: begin
              if (tid_hit_r) res_sup_r <= 1'b1;
              else if (free_any) begin
                res_sup_r             <= 1'b1;
                id_valid_r[free_slot] <= 1'b1;
              end else res_status_r <= tsf_pkg::StatusIdFull;
            end
            tsf_pkg::ModeUpdate: begin
              if (par_hit_r || name_hit_r) begin
                res_sup_r <= 1'b1;
                if (!tid_hit_r) begin
                  if (free_any) id_valid_r[free_slot] <= 1'b1;
                  else res_status_r <= tsf_pkg::StatusIdFull;
                end
              end else if (tid_hit_r) begin
                id_valid_r[tid_slot_r] <= 1'b0;
              end
            end
            default: res_sup_r <= tid_hit_r;
          endcase
          state_r <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sup_r    <= res_sup_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_suppressed = out_sup_r;
  assign out_status     = out_status_r;

endmodule
